FILE: hdl/oust_pkg.sv
// Shared types, sizes and codes for the ordered unique set table.
// Used by every module in the block; depends on nothing else.
package oust_pkg;

	// Table size and derived widths.
	localparam int CAPACITY = 256;
	localparam int POS_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Field widths of the beats.
	localparam int CMD_W       = 2;
	localparam int VAL_W       = 32;
	localparam int IDX_W       = 8;
	localparam int STAT_W      = 3;
	localparam int COUNT_OUT_W = 9;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 48;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (STAT_W + 1 + VAL_W + COUNT_OUT_W);

	// Width used to compare a read index with a cell number.
	localparam int IDX_CW = (POS_W > IDX_W) ? POS_W : IDX_W;

	// Grouping of the match reduction tree.
	localparam int GRP_SIZE = 16;
	localparam int GRP_W    = $clog2(GRP_SIZE);
	localparam int NGRP     = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
	localparam int PAD_N    = NGRP * GRP_SIZE;
	localparam int SUM_W    = POS_W + GRP_W;

	typedef logic signed [VAL_W-1:0] data_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT,
		CMD_DELETE,
		CMD_LOOKUP,
		CMD_READAT
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK,
		STAT_DUP,
		STAT_FULL,
		STAT_ABSENT,
		STAT_BADIDX
	} status_t;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		cmd_t             cmd;
		data_t            value;
		logic [IDX_W-1:0] index;
		logic [CNT_W-1:0] count;
		logic             insert_en;
		logic             delete_en;
		logic [POS_W-1:0] pos;
	} cell_ctrl_t;

endpackage

FILE: hdl/oust_cell.sv
// One storage cell of the table: holds an entry, compares it with the current beat
// and takes its upper neighbour's entry when a deletion closes a gap. Uses oust_pkg.
module oust_cell (
	input  logic                     clk,
	input  oust_pkg::cell_ctrl_t     ctrl,
	input  logic [oust_pkg::POS_W-1:0] cell_num,
	input  oust_pkg::data_t          next_entry,
	output oust_pkg::data_t          entry,
	output logic                     hit_s1
);
	import oust_pkg::*;

	data_t entry_q;
	logic  occupied;
	logic  idx_match;
	logic  at_tail;

	// The cell holds a live entry while its number is below the count.
	assign occupied  = CNT_W'(cell_num) < ctrl.count;
	assign idx_match = IDX_CW'(ctrl.index) == IDX_CW'(cell_num);
	assign at_tail   = CNT_W'(cell_num) == ctrl.count;

	// Registered match: position match for read-at, value match otherwise.
	always_ff @(posedge clk) begin
		if (ctrl.cmd == CMD_READAT) begin
			hit_s1 <= occupied && idx_match;
		end else begin
			hit_s1 <= occupied && (entry_q == ctrl.value);
		end
	end

	// Append at the tail, or shift down from the neighbour above the deleted place.
	always_ff @(posedge clk) begin
		if (ctrl.insert_en && at_tail) begin
			entry_q <= ctrl.value;
		end else if (ctrl.delete_en && (cell_num >= ctrl.pos)) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;

endmodule

FILE: hdl/oust_reduce.sv
// Two-level registered reduction of the cell match flags: membership, matching
// position and the matching entry. Uses oust_pkg.
module oust_reduce (
	input  logic                          clk,
	input  logic [oust_pkg::CAPACITY-1:0] hit,
	input  oust_pkg::data_t               entry [oust_pkg::CAPACITY],
	output logic                          found,
	output logic [oust_pkg::POS_W-1:0]    pos,
	output oust_pkg::data_t               element
);
	import oust_pkg::*;

	logic [PAD_N-1:0] hit_pad;
	data_t            entry_pad [PAD_N];

	logic             grp_any_c  [NGRP];
	logic [GRP_W-1:0] grp_pos_c  [NGRP];
	data_t            grp_data_c [NGRP];
	logic             grp_any_s2  [NGRP];
	logic [GRP_W-1:0] grp_pos_s2  [NGRP];
	data_t            grp_data_s2 [NGRP];

	logic             found_c;
	logic [SUM_W-1:0] pos_c;
	data_t            element_c;
	logic             found_s3;
	logic [POS_W-1:0] pos_s3;
	data_t            element_s3;

	// Pad the row up to whole groups; padding never matches.
	assign hit_pad = PAD_N'(hit);
	for (genvar k = 0; k < PAD_N; k++) begin : g_pad
		if (k < CAPACITY) begin : g_real
			assign entry_pad[k] = entry[k];
		end else begin : g_fill
			assign entry_pad[k] = '0;
		end
	end

	// First level: OR within each group. At most one flag is set in the row.
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_any_c[g]  = 1'b0;
			grp_pos_c[g]  = '0;
			grp_data_c[g] = '0;
			for (int j = 0; j < GRP_SIZE; j++) begin
				if (hit_pad[g*GRP_SIZE + j]) begin
					grp_any_c[g]  = 1'b1;
					grp_pos_c[g]  = grp_pos_c[g] | GRP_W'(j);
					grp_data_c[g] = grp_data_c[g] | entry_pad[g*GRP_SIZE + j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_any_s2  <= grp_any_c;
		grp_pos_s2  <= grp_pos_c;
		grp_data_s2 <= grp_data_c;
	end

	// Second level: OR across the groups, rebuilding the full position.
	always_comb begin
		found_c   = 1'b0;
		pos_c     = '0;
		element_c = '0;
		for (int g = 0; g < NGRP; g++) begin
			if (grp_any_s2[g]) begin
				found_c   = 1'b1;
				pos_c     = pos_c | (SUM_W'(g) << GRP_W) | SUM_W'(grp_pos_s2[g]);
				element_c = element_c | grp_data_s2[g];
			end
		end
	end

	always_ff @(posedge clk) begin
		found_s3   <= found_c;
		pos_s3     <= POS_W'(pos_c);
		element_s3 <= element_c;
	end

	assign found   = found_s3;
	assign pos     = pos_s3;
	assign element = element_s3;

endmodule

FILE: hdl/ordered_unique_set_table_unit.sv
// Ordered unique set table: a row of storage cells holding distinct 32-bit values
// in insertion order. Uses oust_pkg, oust_cell and oust_reduce.
//
// Usage:
// The slave side takes one command beat: s_tuser holds the command (insert, delete,
// lookup, read-at), s_tdata the value and the read index. The master side gives one
// result beat per command: status, found flag, element read and entry count.
// Flow: an accepted beat passes the compare in the cells, the two registered
// levels of the match reduction and the commit step before its result is registered
// on m_tvalid; no new command is accepted while one is in flight.
// A new command is accepted in the cycle after the previous result is registered,
// so one command may wait inside while an earlier result is still held at the
// output. While the receiver stalls, the result register holds its beat and the
// command in flight waits at its commit step; nothing is lost.
// Reset clears the count and the control state; entries need no clearing, since
// only places below the count are ever read. A deletion shifts every later entry
// down one cell, in the same cycle as the count is reduced.
module ordered_unique_set_table_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// s_tdata: value [31:0], index [39:32]
	input  logic [oust_pkg::IN_TDATA_W-1:0]    s_tdata,
	// s_tuser: command [1:0]
	input  logic [oust_pkg::CMD_W-1:0]         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// m_tdata: status [2:0], found [3], element [35:4], count [44:36], zero [47:45]
	output logic [oust_pkg::OUT_TDATA_W-1:0]   m_tdata
);
	import oust_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_GRP,
		ST_RES,
		ST_DONE
	} state_t;

	state_t                 state_q;
	cmd_t                   cmd_q;
	data_t                  value_q;
	logic [IDX_W-1:0]       index_q;
	logic [CNT_W-1:0]       count_q;
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	cell_ctrl_t             ctrl;
	logic [CAPACITY-1:0]    hit_s1;
	data_t                  cell_entry [CAPACITY];
	logic                   found_s3;
	logic [POS_W-1:0]       pos_s3;
	data_t                  element_s3;

	logic                   out_free;
	logic                   commit;
	logic                   is_full;
	logic                   insert_en;
	logic                   delete_en;
	status_t                res_status;
	logic                   res_found;
	data_t                  res_element;
	logic [CNT_W-1:0]       count_next;

	// Commit decisions for the command in flight.
	assign out_free  = !m_tvalid_q || m_tready;
	assign commit    = (state_q == ST_DONE) && out_free;
	assign is_full   = count_q == CNT_W'(CAPACITY);
	assign insert_en = commit && (cmd_q == CMD_INSERT) && !found_s3 && !is_full;
	assign delete_en = commit && (cmd_q == CMD_DELETE) && found_s3;

	assign ctrl.cmd       = cmd_q;
	assign ctrl.value     = value_q;
	assign ctrl.index     = index_q;
	assign ctrl.count     = count_q;
	assign ctrl.insert_en = insert_en;
	assign ctrl.delete_en = delete_en;
	assign ctrl.pos       = pos_s3;

	// The row of cells; each one but the top sees the entry of the cell above it.
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		if (k < CAPACITY - 1) begin : g_mid
			oust_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.cell_num   (POS_W'(k)),
				.next_entry (cell_entry[k+1]),
				.entry      (cell_entry[k]),
				.hit_s1     (hit_s1[k])
			);
		end else begin : g_top
			oust_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.cell_num   (POS_W'(k)),
				.next_entry (cell_entry[k]),
				.entry      (cell_entry[k]),
				.hit_s1     (hit_s1[k])
			);
		end
	end

	oust_reduce u_reduce (
		.clk     (clk),
		.hit     (hit_s1),
		.entry   (cell_entry),
		.found   (found_s3),
		.pos     (pos_s3),
		.element (element_s3)
	);

	// Result fields and the count after this command.
	always_comb begin
		res_status  = STAT_OK;
		res_found   = found_s3;
		res_element = '0;
		count_next  = count_q;
		unique case (cmd_q)
			CMD_INSERT: begin
				if (found_s3) begin
					res_status = STAT_DUP;
				end else if (is_full) begin
					res_status = STAT_FULL;
				end else begin
					count_next = count_q + 1'b1;
				end
			end
			CMD_DELETE: begin
				if (found_s3) begin
					count_next = count_q - 1'b1;
				end else begin
					res_status = STAT_ABSENT;
				end
			end
			CMD_LOOKUP: begin
				res_status = STAT_OK;
			end
			CMD_READAT: begin
				res_found = 1'b0;
				if (found_s3) begin
					res_element = element_s3;
				end else begin
					res_status = STAT_BADIDX;
				end
			end
			default: begin
				res_status = STAT_OK;
			end
		endcase
	end

	// Sequencer, command register, count and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cmd_q      <= CMD_INSERT;
			value_q    <= '0;
			index_q    <= '0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
			out_data_q <= '0;
		end else begin
			// The held beat leaves unless a new result replaces it in this cycle.
			if (m_tvalid_q && m_tready && !commit) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cmd_q   <= cmd_t'(s_tuser);
						value_q <= s_tdata[VAL_W-1:0];
						index_q <= s_tdata[VAL_W +: IDX_W];
						state_q <= ST_CMP;
					end
				end
				ST_CMP: state_q <= ST_GRP;
				ST_GRP: state_q <= ST_RES;
				ST_RES: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						count_q    <= count_next;
						m_tvalid_q <= 1'b1;
						out_data_q <= {OUT_PAD_W'(0), COUNT_OUT_W'(count_next), res_element,
							res_found, res_status};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;

	// Stored values are distinct, so at most one cell can match.
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GRP) |-> $onehot0(hit_s1))
		else $error("more than one cell matched the command");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		insert_en |=> (count_q == CNT_W'($past(count_q) + 1'b1)))
		else $error("insert did not advance the count");

	a_delete_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		delete_en |=> (count_q == CNT_W'($past(count_q) - 1'b1)))
		else $error("delete did not reduce the count");

	a_count_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!(insert_en || delete_en) |=> $stable(count_q))
		else $error("count changed without an insert or delete");

endmodule
